// ----- src/xterm256_to_vga16_color_map_macros.svh -----
// Assertion helpers shared by the color map RTL.
`ifndef XTERM256_TO_VGA16_COLOR_MAP_MACROS_SVH
`define XTERM256_TO_VGA16_COLOR_MAP_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced during reset.
`define X2V_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x2v: same-cycle check failed");

// Next-cycle implication, sampled on clk and silenced during reset.
`define X2V_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x2v: next-cycle check failed");

`endif

// ----- src/x2v_pkg.sv -----
package x2v_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned LVL_N     = 4;
    localparam int unsigned PAL_N     = 16;
    localparam int unsigned SQ_W      = 16;
    localparam int unsigned DIST_W    = 18;
    localparam int unsigned VGA_W     = 4;

    localparam logic [7:0] CUBE_BASE   = 8'd16;
    localparam logic [7:0] GREY_BASE   = 8'd232;
    localparam logic [7:0] CUBE_STEP   = 8'd51;
    localparam logic [7:0] GREY_STEP   = 8'd10;
    localparam logic [7:0] GREY_OFFSET = 8'd8;

    // Operation codes carried on the operation input.
    typedef enum logic {OP_INDEX = 1'b0, OP_RGB = 1'b1} op_t;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [VGA_W-1:0]  vga_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // Decoded color plus the direct result for the low sixteen indices.
    typedef struct packed {
        logic  pass;
        vga_t  idx;
        rgb_t  rgb;
    } dec_t;

    // The VGA palette uses only four component levels.
    localparam chan_t LEVEL [LVL_N] = '{8'd0, 8'd85, 8'd170, 8'd255};

    // Palette entries as level codes {red, green, blue}, two bits each.
    localparam logic [5:0] PAL_LVL [PAL_N] = '{
        6'b00_00_00, 6'b10_00_00, 6'b00_10_00, 6'b10_01_00,
        6'b00_00_10, 6'b10_00_10, 6'b00_10_10, 6'b10_10_10,
        6'b01_01_01, 6'b11_01_01, 6'b01_11_01, 6'b11_11_01,
        6'b01_01_11, 6'b11_01_11, 6'b01_11_11, 6'b11_11_11
    };

    function automatic sq_t sq_diff(chan_t a, chan_t b);
        chan_t d;
        d = (a >= b) ? chan_t'(a - b) : chan_t'(b - a);
        return sq_t'({8'd0, d} * {8'd0, d});
    endfunction

endpackage

// ----- src/x2v_decode.sv -----
module x2v_decode (
    input  logic                 operation,
    input  x2v_pkg::chan_t       color_index,
    input  x2v_pkg::chan_t       red,
    input  x2v_pkg::chan_t       green,
    input  x2v_pkg::chan_t       blue,
    output x2v_pkg::dec_t        dec
);

    logic [7:0]  q;
    logic [13:0] q_scaled;
    logic [2:0]  dig_r;
    logic [7:0]  rem36;
    logic [10:0] rem_scaled;
    logic [2:0]  dig_g;
    logic [2:0]  dig_b;
    logic [4:0]  grey_q;
    x2v_pkg::chan_t grey_v;
    x2v_pkg::rgb_t  cube_rgb;

    // Digits of the 6x6x6 cube: divide by 36 and by 6 through reciprocals.
    // The scale factors are exact over the cube's index range.
    always_comb
    begin
        q          = color_index - x2v_pkg::CUBE_BASE;
        q_scaled   = 14'({6'd0, q} * 14'd57);
        dig_r      = q_scaled[13:11];
        rem36      = q - 8'({5'd0, dig_r} * 8'd36);
        rem_scaled = 11'({3'd0, rem36} * 11'd43);
        dig_g      = rem_scaled[10:8];
        dig_b      = 3'(rem36 - 8'({5'd0, dig_g} * 8'd6));

        cube_rgb.r = 8'({5'd0, dig_r} * x2v_pkg::CUBE_STEP);
        cube_rgb.g = 8'({5'd0, dig_g} * x2v_pkg::CUBE_STEP);
        cube_rgb.b = 8'({5'd0, dig_b} * x2v_pkg::CUBE_STEP);

        grey_q = 5'(color_index - x2v_pkg::GREY_BASE);
        grey_v = 8'({3'd0, grey_q} * x2v_pkg::GREY_STEP) + x2v_pkg::GREY_OFFSET;
    end

    always_comb
    begin
        dec.pass = 1'b0;
        dec.idx  = color_index[3:0];
        if (operation == x2v_pkg::OP_RGB)
        begin
            dec.rgb = '{r: red, g: green, b: blue};
        end
        else if (color_index < x2v_pkg::CUBE_BASE)
        begin
            dec.pass = 1'b1;
            dec.rgb  = '0;
        end
        else if (color_index < x2v_pkg::GREY_BASE)
        begin
            dec.rgb = cube_rgb;
        end
        else
        begin
            dec.rgb = '{r: grey_v, g: grey_v, b: grey_v};
        end
    end

endmodule

// ----- src/xterm256_to_vga16_color_map.sv -----
// Maps an xterm 256-color index (operation 0) or a direct 8-bit RGB triple
// (operation 1) to the nearest of the 16 VGA palette colors by squared
// Euclidean distance, the lowest palette index winning a tie; indices 0 to
// 15 come out unchanged. Each input transfer yields exactly one output
// transfer, in order. The block is a four-stage pipeline (input register,
// decoded color, per-channel squared distances, result register) and
// accepts one transfer every cycle unless it is full and out_ready is low;
// an accepted transfer passes through the four registers in that order
// before it raises out_valid. in_ready is a combinational chain through
// the stage valid bits back from out_ready, so a full pipeline stalls only
// while the output holds a result nobody has taken.
`include "xterm256_to_vga16_color_map_macros.svh"

module xterm256_to_vga16_color_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  x2v_pkg::chan_t       color_index,
    input  x2v_pkg::chan_t       red,
    input  x2v_pkg::chan_t       green,
    input  x2v_pkg::chan_t       blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output x2v_pkg::vga_t        vga_color
);

    // Stage valid bits, from input side to output side.
    logic in_v_reg, dec_v_reg, sq_v_reg, out_v_reg;
    logic in_en, dec_en, sq_en, out_en;

    // Input register: raw fields of the accepted transfer.
    logic           op_reg;
    x2v_pkg::chan_t idx_reg, red_reg, green_reg, blue_reg;

    // Decoded color.
    x2v_pkg::dec_t  dec_next, dec_reg;

    // Squared distances of each channel to each of the four palette levels,
    // plus the direct result carried along for the low sixteen indices.
    x2v_pkg::sq_t   sq_next [3][x2v_pkg::LVL_N];
    x2v_pkg::sq_t   sq_reg  [3][x2v_pkg::LVL_N];
    logic           pass_reg;
    x2v_pkg::vga_t  pass_idx_reg;

    // Distance search and result.
    x2v_pkg::dist_t pal_dist [x2v_pkg::PAL_N];
    x2v_pkg::dist_t d8 [8];
    x2v_pkg::vga_t  i8 [8];
    x2v_pkg::dist_t d4 [4];
    x2v_pkg::vga_t  i4 [4];
    x2v_pkg::dist_t d2 [2];
    x2v_pkg::vga_t  i2 [2];
    x2v_pkg::vga_t  vga_next, vga_reg;

    // A stage may load when it is empty or its content moves on this cycle.
    assign out_en   = !out_v_reg || out_ready;
    assign sq_en    = !sq_v_reg  || out_en;
    assign dec_en   = !dec_v_reg || sq_en;
    assign in_en    = !in_v_reg  || dec_en;
    assign in_ready = in_en;

    assign out_valid = out_v_reg;
    assign vga_color = vga_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            dec_v_reg <= 1'b0;
            sq_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_v_reg <= in_valid;
            end
            if (dec_en)
            begin
                dec_v_reg <= in_v_reg;
            end
            if (sq_en)
            begin
                sq_v_reg <= dec_v_reg;
            end
            if (out_en)
            begin
                out_v_reg <= sq_v_reg;
            end
        end
    end

    // Decode an index into a color, or pass the direct triple through.
    x2v_decode u_decode (
        .operation   (op_reg),
        .color_index (idx_reg),
        .red         (red_reg),
        .green       (green_reg),
        .blue        (blue_reg),
        .dec         (dec_next)
    );

    always_comb
    begin
        for (int l = 0; l < x2v_pkg::LVL_N; l++)
        begin
            sq_next[0][l] = x2v_pkg::sq_diff(dec_reg.rgb.r, x2v_pkg::LEVEL[l]);
            sq_next[1][l] = x2v_pkg::sq_diff(dec_reg.rgb.g, x2v_pkg::LEVEL[l]);
            sq_next[2][l] = x2v_pkg::sq_diff(dec_reg.rgb.b, x2v_pkg::LEVEL[l]);
        end
    end

    // Sum the three channel terms per palette entry, then a four-level
    // minimum tree. The left operand always covers lower indices, so
    // taking it on equality keeps the lowest index on a tie.
    always_comb
    begin
        for (int k = 0; k < x2v_pkg::PAL_N; k++)
        begin
            pal_dist[k] = x2v_pkg::dist_t'(sq_reg[0][x2v_pkg::PAL_LVL[k][5:4]])
                        + x2v_pkg::dist_t'(sq_reg[1][x2v_pkg::PAL_LVL[k][3:2]])
                        + x2v_pkg::dist_t'(sq_reg[2][x2v_pkg::PAL_LVL[k][1:0]]);
        end
        for (int k = 0; k < 8; k++)
        begin
            if (pal_dist[2*k] <= pal_dist[2*k+1])
            begin
                d8[k] = pal_dist[2*k];
                i8[k] = x2v_pkg::vga_t'(2*k);
            end
            else
            begin
                d8[k] = pal_dist[2*k+1];
                i8[k] = x2v_pkg::vga_t'(2*k+1);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (d8[2*k] <= d8[2*k+1])
            begin
                d4[k] = d8[2*k];
                i4[k] = i8[2*k];
            end
            else
            begin
                d4[k] = d8[2*k+1];
                i4[k] = i8[2*k+1];
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            if (d4[2*k] <= d4[2*k+1])
            begin
                d2[k] = d4[2*k];
                i2[k] = i4[2*k];
            end
            else
            begin
                d2[k] = d4[2*k+1];
                i2[k] = i4[2*k+1];
            end
        end
        if (pass_reg)
        begin
            vga_next = pass_idx_reg;
        end
        else if (d2[0] <= d2[1])
        begin
            vga_next = i2[0];
        end
        else
        begin
            vga_next = i2[1];
        end
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            op_reg    <= operation;
            idx_reg   <= color_index;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (dec_en)
        begin
            dec_reg <= dec_next;
        end
        if (sq_en)
        begin
            sq_reg       <= sq_next;
            pass_reg     <= dec_reg.pass;
            pass_idx_reg <= dec_reg.idx;
        end
        if (out_en)
        begin
            vga_reg <= vga_next;
        end
    end

    // A taker that is ready must never see the pipeline refuse new input.
    `X2V_ASSERT_NOW(a_ready_chain, out_ready, in_ready)
    // An accepted transfer always lands in the input register.
    `X2V_ASSERT_NEXT(a_in_lands, in_valid && in_ready, in_v_reg)
    // A valid distance stage that advances always produces a result.
    `X2V_ASSERT_NEXT(a_sq_to_out, sq_v_reg && out_en, out_v_reg)

endmodule
